### rtl/tlik_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, constants and tables of the two-link inverse kinematics block.
// ----------------------------------------------------------------------------
package tlik_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_UPPER_LINK     = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_LOWER_LINK     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SHOULDER_OFFSET = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ELBOW_OFFSET   = 3'd3;

    localparam logic [14:0] UPPER_LINK_RST = 15'd256;
    localparam logic [14:0] LOWER_LINK_RST = 15'd512;

    // CORDIC lane input width and working width.
    localparam int CIN = 35;
    localparam int CW  = 46;
    localparam int ZW  = 28;

    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [26:0]   PULSE_K_Q16 = 27'sd41721513;
    localparam logic signed [44:0]   PULSE_RND   = 45'sd134217728;
    localparam logic [11:0] PULSE_MIN  = 12'd500;
    localparam logic [11:0] PULSE_MAX  = 12'd2500;
    localparam int          PULSE_SPAN = 2000;

    localparam logic [24:0] ATAN_HEAD [8] = '{
        25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331,
        25'd1047214,  25'd524117,  25'd262123,  25'd131069
    };

    typedef struct packed {
        logic                  reach;
        logic signed [15:0]    x;
        logic signed [15:0]    y;
        logic signed [CIN-1:0] n;
        logic signed [CIN-1:0] m;
        logic [30:0]           s;
    } t_mid;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Arctangent of 2^-i with 24 fraction bits; nothing below the last bit.
    function automatic logic [24:0] f_atan_step(input int i);
        logic [24:0] r;
        r = '0;
        if (i < 8) begin
            r = ATAN_HEAD[i];
        end else if (i <= 24) begin
            r = 25'd1 << (24 - i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/tlik_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_front
// Takes targets, squares the geometry, tests reach and extracts the square
// root for the elbow sine term, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module tlik_front import tlik_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_target_x,
    input  wire logic signed [15:0] i_target_y,
    input  wire logic [14:0]        i_l1,
    input  wire logic [14:0]        i_l2,
    input  wire t_q_stat            i_q_stat,
    output logic                    o_push,
    output t_mid                    o_mid
);
    localparam int QN = 31;
    localparam int NF = 6 + QN;

    logic [NF-1:0] r_fv;
    logic          w_en;

    logic signed [15:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2, r_x3, r_y3, r_x4, r_y4;
    logic [30:0] r_xx, r_yy;
    logic [29:0] r_l1sq, r_l2sq, r_l12, r_difsq, r_l1sq2, r_l2sq2, r_l122, r_difsq2;
    logic [31:0] r_sumsq, r_sumsq2, r_r2;
    logic        r_rch3, r_rch4;
    logic signed [CIN-1:0] r_n3, r_m3, r_n4, r_m4;
    logic [30:0] r_d3;
    logic [61:0] r_dd;
    logic [63:0] r_nn;

    logic [33:0] r_qr [0:QN];
    logic [30:0] r_qq [0:QN];
    logic [61:0] r_qv [0:QN];
    logic signed [15:0]    r_qx [0:QN];
    logic signed [15:0]    r_qy [0:QN];
    logic signed [CIN-1:0] r_qn [0:QN];
    logic signed [CIN-1:0] r_qm [0:QN];
    logic                  r_qrch [0:QN];

    logic signed [31:0] w_xx, w_yy, w_difsq;
    logic [29:0] w_l1sq, w_l2sq, w_l12;
    logic [15:0] w_sum;
    logic signed [15:0] w_dif;
    logic [31:0] w_sumsq;
    logic signed [CIN-1:0] w_n, w_m;
    logic [CIN-1:0] w_nabs;
    logic [63:0] w_v;

    assign w_en    = !(r_fv[NF-1] && i_q_stat.full);
    assign o_stall = !w_en;
    assign o_push  = r_fv[NF-1] && !i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[NF-2:0], i_valid};
        end
    end

    assign w_xx    = r_x0 * r_x0;
    assign w_yy    = r_y0 * r_y0;
    assign w_l1sq  = i_l1 * i_l1;
    assign w_l2sq  = i_l2 * i_l2;
    assign w_l12   = i_l1 * i_l2;
    assign w_sum   = {1'b0, i_l1} + {1'b0, i_l2};
    assign w_sumsq = w_sum * w_sum;
    assign w_dif   = $signed({1'b0, i_l1}) - $signed({1'b0, i_l2});
    assign w_difsq = w_dif * w_dif;

    assign w_n = $signed({3'b0, r_r2}) - $signed({5'b0, r_l1sq2})
               - $signed({5'b0, r_l2sq2});
    assign w_m = $signed({5'b0, r_l1sq2}) + $signed({3'b0, r_r2})
               - $signed({5'b0, r_l2sq2});

    assign w_nabs = r_n3[CIN-1] ? CIN'(-r_n3) : CIN'(r_n3);
    assign w_v    = {2'b0, r_dd} - r_nn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= i_target_x;
            r_y0 <= i_target_y;
            // Squares and link products.
            r_x1     <= r_x0;
            r_y1     <= r_y0;
            r_xx     <= w_xx[30:0];
            r_yy     <= w_yy[30:0];
            r_l1sq   <= w_l1sq;
            r_l2sq   <= w_l2sq;
            r_l12    <= w_l12;
            r_sumsq  <= w_sumsq;
            r_difsq  <= w_difsq[29:0];
            // Squared radius.
            r_x2     <= r_x1;
            r_y2     <= r_y1;
            r_r2     <= {1'b0, r_xx} + {1'b0, r_yy};
            r_l1sq2  <= r_l1sq;
            r_l2sq2  <= r_l2sq;
            r_l122   <= r_l12;
            r_sumsq2 <= r_sumsq;
            r_difsq2 <= r_difsq;
            // Reach test and cosine-law terms.
            r_x3   <= r_x2;
            r_y3   <= r_y2;
            r_rch3 <= (r_r2 <= r_sumsq2) && (r_r2 >= {2'b0, r_difsq2});
            r_n3   <= w_n;
            r_m3   <= w_m;
            r_d3   <= {r_l122, 1'b0};
            // D squared and N squared.
            r_x4   <= r_x3;
            r_y4   <= r_y3;
            r_rch4 <= r_rch3;
            r_n4   <= r_n3;
            r_m4   <= r_m3;
            r_dd   <= r_d3 * r_d3;
            r_nn   <= w_nabs[31:0] * w_nabs[31:0];
            // Radicand, entry of the root pipeline.
            r_qr[0]   <= '0;
            r_qq[0]   <= '0;
            r_qv[0]   <= w_v[61:0];
            r_qx[0]   <= r_x4;
            r_qy[0]   <= r_y4;
            r_qn[0]   <= r_n4;
            r_qm[0]   <= r_m4;
            r_qrch[0] <= r_rch4;
        end
    end

    for (genvar k = 0; k < QN; k++) begin : g_root
        logic [35:0] w_rem;
        logic [35:0] w_trial;
        logic [35:0] w_diff;
        logic        w_ge;

        assign w_rem   = {r_qr[k], r_qv[k][61:60]};
        assign w_trial = {3'b0, r_qq[k], 2'b01};
        assign w_diff  = w_rem - w_trial;
        assign w_ge    = w_rem >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_qr[k+1]   <= w_ge ? w_diff[33:0] : w_rem[33:0];
                r_qq[k+1]   <= {r_qq[k][29:0], w_ge};
                r_qv[k+1]   <= {r_qv[k][59:0], 2'b00};
                r_qx[k+1]   <= r_qx[k];
                r_qy[k+1]   <= r_qy[k];
                r_qn[k+1]   <= r_qn[k];
                r_qm[k+1]   <= r_qm[k];
                r_qrch[k+1] <= r_qrch[k];
            end
        end
    end

    always_comb begin
        o_mid.reach = r_qrch[QN];
        o_mid.x     = r_qx[QN];
        o_mid.y     = r_qy[QN];
        o_mid.n     = r_qn[QN];
        o_mid.m     = r_qm[QN];
        o_mid.s     = r_qq[QN];
    end

endmodule
`default_nettype wire

### rtl/tlik_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_queue
// Two-entry queue between the front and the back pipelines.
// ----------------------------------------------------------------------------
module tlik_queue import tlik_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_mid i_data,
    input  wire logic i_pop,
    output t_mid      o_data,
    output t_q_stat   o_stat
);
    t_mid       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

### rtl/tlik_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) with 12 fraction bits.
// Stages: input, normalisation, quadrant, rotation steps, output register.
// ----------------------------------------------------------------------------
module tlik_cordic import tlik_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [CIN-1:0] i_x,
    input  wire logic signed [CIN-1:0] i_y,
    output logic signed [15:0]         o_angle
);
    localparam int NS = 6;

    logic signed [CW-1:0] r_nx [0:NS];
    logic signed [CW-1:0] r_ny [0:NS];
    logic [40:0]          r_nm [0:NS];
    logic                 r_nz [0:NS];

    logic signed [CW-1:0] r_cx [0:STEPS];
    logic signed [CW-1:0] r_cy [0:STEPS];
    logic signed [ZW-1:0] r_cz [0:STEPS];
    logic                 r_cq [0:STEPS];

    logic signed [CW-1:0] w_x, w_y, w_ax, w_ay, w_x2, w_y2;
    logic signed [ZW-1:0] w_zr;

    assign w_x  = CW'(i_x);
    assign w_y  = CW'(i_y);
    assign w_ax = w_x[CW-1] ? -w_x : w_x;
    assign w_ay = w_y[CW-1] ? -w_y : w_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0] <= w_x;
            r_ny[0] <= w_y;
            r_nm[0] <= (w_ax > w_ay) ? w_ax[40:0] : w_ay[40:0];
            r_nz[0] <= (w_ax == '0) && (w_ay == '0);
        end
    end

    // Scale up so that the larger magnitude reaches 2^40: the shifts here
    // leave it just below, the doubling in the quadrant stage finishes it.
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic w_fit;
        assign w_fit = r_nm[j][40:40-SH] == '0;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[j+1] <= w_fit ? (r_nx[j] <<< SH) : r_nx[j];
                r_ny[j+1] <= w_fit ? (r_ny[j] <<< SH) : r_ny[j];
                r_nm[j+1] <= w_fit ? (r_nm[j] << SH) : r_nm[j];
                r_nz[j+1] <= r_nz[j];
            end
        end
    end

    assign w_x2 = r_nx[NS] <<< 1;
    assign w_y2 = r_ny[NS] <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cq[0] <= r_nz[NS];
            if (w_x2[CW-1]) begin
                if (!w_y2[CW-1]) begin
                    r_cx[0] <= w_y2;
                    r_cy[0] <= -w_x2;
                    r_cz[0] <= HALF_PI_Q24;
                end else begin
                    r_cx[0] <= -w_y2;
                    r_cy[0] <= w_x2;
                    r_cz[0] <= -HALF_PI_Q24;
                end
            end else begin
                r_cx[0] <= w_x2;
                r_cy[0] <= w_y2;
                r_cz[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [CW-1:0] w_dx, w_dy;
        logic signed [ZW-1:0] w_at;
        assign w_dx = r_cy[i] >>> i;
        assign w_dy = r_cx[i] >>> i;
        assign w_at = $signed({3'b0, f_atan_step(i)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cq[i+1] <= r_cq[i];
                if (!r_cy[i][CW-1]) begin
                    r_cx[i+1] <= r_cx[i] + w_dx;
                    r_cy[i+1] <= r_cy[i] - w_dy;
                    r_cz[i+1] <= r_cz[i] + w_at;
                end else begin
                    r_cx[i+1] <= r_cx[i] - w_dx;
                    r_cy[i+1] <= r_cy[i] + w_dy;
                    r_cz[i+1] <= r_cz[i] - w_at;
                end
            end
        end
    end

    assign w_zr = r_cz[STEPS] + ZW'(2048);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= r_cq[STEPS] ? '0 : w_zr[ZW-1:12];
        end
    end

endmodule
`default_nettype wire

### rtl/tlik_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_back
// Runs the three arctangents, forms the joint angles and the servo pulses,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module tlik_back import tlik_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_q_stat            i_q_stat,
    input  wire t_mid               i_mid,
    output logic                    o_pop,
    input  wire logic signed [14:0] i_shoulder_offset,
    input  wire logic signed [14:0] i_elbow_offset,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_reachable,
    output logic signed [15:0]      o_shoulder_angle,
    output logic [13:0]             o_elbow_angle,
    output logic [11:0]             o_shoulder_pulse,
    output logic [11:0]             o_elbow_pulse
);
    localparam int LC = CORDIC_STEPS + 9;

    logic          w_en;
    logic [LC-1:0] r_bv;
    logic [LC-1:0] r_brch;
    logic signed [15:0] w_a0, w_a1, w_a2;

    logic               r_p1v, r_p1r, r_p2v, r_p2r;
    logic signed [16:0] r_sh1, r_sh2;
    logic signed [15:0] r_el1, r_el2;
    logic signed [17:0] r_as, r_ae;
    logic signed [44:0] r_ps, r_pe;

    function automatic logic [11:0] f_pulse(input logic signed [44:0] p);
        logic signed [44:0] q;
        logic [11:0]        r;
        q = (p + PULSE_RND) >>> 28;
        if (q < 0) begin
            r = PULSE_MIN;
        end else if (q > PULSE_SPAN) begin
            r = PULSE_MAX;
        end else begin
            r = q[11:0] + PULSE_MIN;
        end
        return r;
    endfunction

    assign w_en  = !(o_valid && i_stall);
    assign o_pop = w_en && !i_q_stat.empty;

    tlik_cordic #(.STEPS(CORDIC_STEPS)) u_target (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (CIN'(i_mid.x)),
        .i_y     (CIN'(i_mid.y)),
        .o_angle (w_a0)
    );

    tlik_cordic #(.STEPS(CORDIC_STEPS)) u_elbow (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (i_mid.n),
        .i_y     ($signed({4'b0, i_mid.s})),
        .o_angle (w_a1)
    );

    tlik_cordic #(.STEPS(CORDIC_STEPS)) u_inner (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (i_mid.m),
        .i_y     ($signed({4'b0, i_mid.s})),
        .o_angle (w_a2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv    <= '0;
            r_p1v   <= 1'b0;
            r_p2v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r_bv    <= {r_bv[LC-2:0], !i_q_stat.empty};
            r_p1v   <= r_bv[LC-1];
            r_p2v   <= r_p1v;
            o_valid <= r_p2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_brch <= {r_brch[LC-2:0], i_mid.reach};
            // Joint angles and offset sums.
            r_p1r <= r_brch[LC-1];
            r_sh1 <= 17'(w_a0) - 17'(w_a2);
            r_el1 <= w_a1;
            r_as  <= 18'(i_shoulder_offset) + 18'(w_a0) - 18'(w_a2);
            r_ae  <= 18'(i_elbow_offset) + 18'(w_a1);
            // Scale to microseconds.
            r_p2r <= r_p1r;
            r_sh2 <= r_sh1;
            r_el2 <= r_el1;
            r_ps  <= r_as * PULSE_K_Q16;
            r_pe  <= r_ae * PULSE_K_Q16;
            // An unreachable target reports all zeros.
            o_reachable      <= r_p2r;
            o_shoulder_angle <= r_p2r ? r_sh2[15:0] : '0;
            o_elbow_angle    <= r_p2r ? r_el2[13:0] : '0;
            o_shoulder_pulse <= r_p2r ? f_pulse(r_ps) : '0;
            o_elbow_pulse    <= r_p2r ? f_pulse(r_pe) : '0;
        end
    end

endmodule
`default_nettype wire

### rtl/two_link_inverse_kinematics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Two-link planar arm inverse kinematics with servo pulse conversion.
// ----------------------------------------------------------------------------
// Usage:
// A target (i_target_x, i_target_y) is a request taken when i_valid is high
// and o_stall is low. Each request gives exactly one result on o_valid, held
// until taken at an edge with i_stall low. Results keep request order.
// The front pipeline (squares, reach test, one square-root bit per stage)
// feeds a two-entry queue; the back pipeline runs three CORDIC lanes and the
// pulse conversion. A new request can enter every cycle while o_stall is low;
// on its way it passes the 31 root stages and the CORDIC_STEPS + 9 stages of
// a CORDIC lane. A held result freezes the back pipeline; once the queue is
// full and the front holds a finished request, the front freezes too and
// o_stall rises. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties all pipelines and sets the links
// to 1.0 and 2.0 and the offsets to zero. Write registers through
// i_cfg_we / i_cfg_addr / i_cfg_data only while no request is in flight.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics import tlik_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_target_x,
    input  wire logic signed [15:0] i_target_y,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [14:0]        i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_reachable,
    output logic signed [15:0]      o_shoulder_angle,
    output logic [13:0]             o_elbow_angle,
    output logic [11:0]             o_shoulder_pulse,
    output logic [11:0]             o_elbow_pulse
);
    logic [14:0]        r_upper_link;
    logic [14:0]        r_lower_link;
    logic signed [14:0] r_shoulder_offset;
    logic signed [14:0] r_elbow_offset;

    t_q_stat w_q_stat;
    t_mid    w_front_mid;
    t_mid    w_queue_mid;
    logic    w_push;
    logic    w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_link      <= UPPER_LINK_RST;
            r_lower_link      <= LOWER_LINK_RST;
            r_shoulder_offset <= '0;
            r_elbow_offset    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_UPPER_LINK:      r_upper_link      <= i_cfg_data;
                CFG_LOWER_LINK:      r_lower_link      <= i_cfg_data;
                CFG_SHOULDER_OFFSET: r_shoulder_offset <= $signed(i_cfg_data);
                CFG_ELBOW_OFFSET:    r_elbow_offset    <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    tlik_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_l1       (r_upper_link),
        .i_l2       (r_lower_link),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_mid      (w_front_mid)
    );

    tlik_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_mid),
        .i_pop   (w_pop),
        .o_data  (w_queue_mid),
        .o_stat  (w_q_stat)
    );

    tlik_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_stat          (w_q_stat),
        .i_mid             (w_queue_mid),
        .o_pop             (w_pop),
        .i_shoulder_offset (r_shoulder_offset),
        .i_elbow_offset    (r_elbow_offset),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_reachable       (o_reachable),
        .o_shoulder_angle  (o_shoulder_angle),
        .o_elbow_angle     (o_elbow_angle),
        .o_shoulder_pulse  (o_shoulder_pulse),
        .o_elbow_pulse     (o_elbow_pulse)
    );

`ifndef SYNTHESIS
    // The front only holds off requests while the queue is full.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q_stat.full)
        else $error("input stalled with room in the queue");

    // An unreachable target reports zeros everywhere.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reachable) |-> (o_shoulder_angle == '0 && o_elbow_angle == '0
            && o_shoulder_pulse == '0 && o_elbow_pulse == '0))
        else $error("unreachable result carries nonzero fields");

    // Reachable results have saturated pulses.
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reachable) |-> (o_shoulder_pulse >= PULSE_MIN
            && o_shoulder_pulse <= PULSE_MAX && o_elbow_pulse >= PULSE_MIN
            && o_elbow_pulse <= PULSE_MAX))
        else $error("servo pulse out of range");
`endif

endmodule
`default_nettype wire

### sim/tb_two_link_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// tb_two_link_inverse_kinematics
// Self-checking bench for the two-link inverse kinematics block: directed and
// random targets over several link and offset settings, each result compared
// in order against a bit-accurate software solution of the arm.
// ----------------------------------------------------------------------------
class ik_scoreboard;
    typedef struct {
        logic        reach;
        logic [15:0] shoulder;
        logic [13:0] elbow;
        logic [11:0] sh_pulse;
        logic [11:0] el_pulse;
    } ik_result_t;

    ik_result_t pending[$];
    longint     l1, l2, sh_off, el_off;
    int         errors;
    int         checked;
    int         reach_count;

    function new();
        errors      = 0;
        checked     = 0;
        reach_count = 0;
        set_defaults();
    endfunction

    function void set_defaults();
        l1     = 256;
        l2     = 512;
        sh_off = 0;
        el_off = 0;
    endfunction

    function void write_reg(int idx, logic [14:0] val);
        case (idx)
            0: l1 = val;
            1: l2 = val;
            2: sh_off = longint'($signed(val));
            3: el_off = longint'($signed(val));
            default: ;
        endcase
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    static function longint arc_step(int i);
        longint head[8];
        head = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
        if (i < 8) return head[i];
        if (i <= 24) return longint'(1) << (24 - i);
        return 0;
    endfunction

    static function longint vector_angle(longint y, longint x);
        longint ax, ay, m, z, t, dx, dy;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        m  = ax > ay ? ax : ay;
        z  = 0;
        if (m == 0) return 0;
        while (m < (longint'(1) << 40)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 26353589;
            end else begin
                x = -y;
                y = t;
                z = -26353589;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + arc_step(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - arc_step(i);
            end
        end
        return floor_shift(z + 2048, 12);
    endfunction

    static function logic [11:0] servo_width(longint off, longint ang);
        longint p;
        p = floor_shift((off + ang) * 41721513 + (longint'(1) << 27), 28) + 500;
        if (p < 500) p = 500;
        if (p > 2500) p = 2500;
        return p[11:0];
    endfunction

    // Notes an accepted request and queues the solution it must produce.
    function void note_request(logic signed [15:0] tx, logic signed [15:0] ty);
        ik_result_t e;
        longint x, y, r2, sum, dif, n, d, s, el, sh;
        x   = tx;
        y   = ty;
        r2  = x * x + y * y;
        sum = l1 + l2;
        dif = l1 - l2;
        if (r2 > sum * sum || r2 < dif * dif) begin
            e = '{1'b0, '0, '0, '0, '0};
        end else begin
            n  = r2 - l1 * l1 - l2 * l2;
            d  = 2 * l1 * l2;
            s  = int_sqrt(longint'(longint'(d * d) - longint'(n * n)));
            el = vector_angle(s, n);
            sh = vector_angle(y, x) - vector_angle(s, l1 * l1 + r2 - l2 * l2);
            e.reach    = 1'b1;
            e.shoulder = sh[15:0];
            e.elbow    = el[13:0];
            e.sh_pulse = servo_width(sh_off, sh);
            e.el_pulse = servo_width(el_off, el);
        end
        pending.push_back(e);
    endfunction

    function void check_result(logic rc, logic [15:0] sh, logic [13:0] el,
                               logic [11:0] sp, logic [11:0] ep);
        ik_result_t e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: result with nothing expected");
            return;
        end
        e = pending.pop_front();
        checked++;
        if (rc) reach_count++;
        if (rc !== e.reach || sh !== e.shoulder || el !== e.elbow ||
            sp !== e.sh_pulse || ep !== e.el_pulse) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: exp r=%0b sh=%0d el=%0d sp=%0d ep=%0d, got r=%0b sh=%0d el=%0d sp=%0d ep=%0d",
                         e.reach, $signed(e.shoulder), e.elbow, e.sh_pulse, e.el_pulse,
                         rc, $signed(sh), el, sp, ep);
        end
    endfunction
endclass

module tb_two_link_inverse_kinematics;
    import tlik_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_target_x = '0;
    logic signed [15:0] i_target_y = '0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr = '0;
    logic [14:0]        i_cfg_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_reachable;
    logic signed [15:0] o_shoulder_angle;
    logic [13:0]        o_elbow_angle;
    logic [11:0]        o_shoulder_pulse;
    logic [11:0]        o_elbow_pulse;

    ik_scoreboard solver = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    int  cycle_count = 0;
    int  sent_count = 0;
    localparam int LATENCY = 80;
    localparam int CYCLE_LIMIT = 400000;

    two_link_inverse_kinematics dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            solver.check_result(o_reachable, o_shoulder_angle, o_elbow_angle,
                                o_shoulder_pulse, o_elbow_pulse);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Valid stays high after an accepted request; the next request or a
    // drain decides its following value, so it is assigned once per edge.
    task automatic send_target(logic signed [15:0] tx, logic signed [15:0] ty);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_target_x <= tx;
        i_target_y <= ty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        solver.note_request(tx, ty);
        sent_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (solver.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_AW-1:0] idx, logic [14:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        solver.write_reg(idx, val);
    endtask

    task automatic set_arm(logic [14:0] a, logic [14:0] b, logic [14:0] so, logic [14:0] eo);
        drain();
        write_cfg(CFG_UPPER_LINK, a);
        write_cfg(CFG_LOWER_LINK, b);
        write_cfg(CFG_SHOULDER_OFFSET, so);
        write_cfg(CFG_ELBOW_OFFSET, eo);
        i_cfg_we <= 1'b0;
    endtask

    function automatic longint ScoreHelper(longint r, longint x);
        return solver.int_sqrt(r * r - x * x);
    endfunction

    // Mostly targets inside the outer reach circle, with some arbitrary points.
    task automatic random_targets(int count);
        longint reach, r, ang_x, ang_y;
        logic signed [15:0] tx, ty;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0) begin
                tx = 16'($urandom);
                ty = 16'($urandom);
            end else begin
                reach = solver.l1 + solver.l2;
                if (reach > 32000) reach = 32000;
                r = $urandom_range(reach);
                ang_x = $urandom_range(2 * r) - r;
                ang_y = int'(ScoreHelper(r, ang_x));
                if ($urandom_range(1)) ang_y = -ang_y;
                tx = 16'(ang_x);
                ty = 16'(ang_y);
            end
            send_target(tx, ty);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset arm, field extremes, origin, rim and inner edge.
        send_target(16'sh7FFF, 16'sh7FFF);
        send_target(-16'sh8000, -16'sh8000);
        send_target(0, 0);
        send_target(16'sd768, 0);
        send_target(-16'sd256, 0);
        send_target(0, -16'sd768);
        send_target(-16'sd500, 16'sd100);
        send_target(-16'sd500, -16'sd100);
        send_target(16'sd300, 16'sd300);
        // Equal links: origin is reachable with the elbow folded.
        set_arm(15'd400, 15'd400, 15'd12868, -15'sd12868);
        send_target(0, 0);
        send_target(16'sd800, 0);
        send_target(-16'sd200, 16'sd500);
        // Zero-length links and the register extremes.
        set_arm(15'd0, 15'd0, 15'h7FFF, 15'h4000);
        send_target(0, 0);
        send_target(16'sd1, 0);
        set_arm(15'd32767, 15'd1, 15'd0, 15'd0);
        send_target(16'sh7FFF, 0);
        send_target(0, -16'sh7FFF);
        send_target(-16'sh7FFE, 16'sd5);
        set_arm(15'd1, 15'd32767, -15'sd12868, 15'd12868);
        send_target(16'sh7FFF, -16'sd100);
        send_target(-16'sd20000, -16'sd20000);

        set_arm(15'd256, 15'd512, 15'd0, 15'd0);
        send_idle_pct = 6;
        recv_idle_pct = 65;
        random_targets(140);
        set_arm(15'd3000, 15'd2000, 15'd1000, -15'sd3000);
        send_idle_pct = 65;
        recv_idle_pct = 6;
        random_targets(140);
        set_arm(15'd16000, 15'd16000, 15'd0, 15'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Long receiver hold-off so the block backs up into o_stall.
        hold_cycles = 200;
        random_targets(130);
        set_arm(15'($urandom), 15'($urandom), 15'($urandom_range(25736) - 12868),
                15'($urandom_range(25736) - 12868));
        random_targets(120);
        drain();

        $display("Sent %0d targets over several arm settings; %0d results checked, %0d reachable.",
                 sent_count, solver.checked, solver.reach_count);
        if (solver.errors == 0 && solver.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Mismatch count: %0d", solver.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### sim.f
rtl/tlik_pkg.sv
rtl/tlik_front.sv
rtl/tlik_queue.sv
rtl/tlik_cordic.sv
rtl/tlik_back.sv
rtl/two_link_inverse_kinematics.sv
sim/tb_two_link_inverse_kinematics.sv
